FILE: rtl/deq_pkg.sv
package deq_pkg;

	localparam int WORD_W = 32;
	localparam int OCC_W  = 4;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [OCC_W-1:0]         occ_t;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	// one-hot shift command broadcast to every cell, already gated by accept
	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop_front;
		logic pop_back;
	} ctrl_t;

endpackage

FILE: rtl/deq_in_if.sv
interface deq_in_if;
	import deq_pkg::*;

	logic  valid;
	logic  ready;
	op_t   opcode;
	word_t data_in;

	modport source (output valid, output opcode, output data_in, input ready);
	modport sink   (input valid, input opcode, input data_in, output ready);

endinterface

FILE: rtl/deq_out_if.sv
interface deq_out_if;
	import deq_pkg::*;

	logic    valid;
	logic    ready;
	word_t   data_out;
	status_t status;
	logic    is_empty;
	logic    is_full;
	occ_t    occupancy;

	modport source (
		output valid, output data_out, output status, output is_empty,
		output is_full, output occupancy, input ready
	);
	modport sink (
		input valid, input data_out, input status, input is_empty,
		input is_full, input occupancy, output ready
	);

endinterface

FILE: rtl/deq_cell.sv
module deq_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  deq_pkg::ctrl_t ctrl,
	input  deq_pkg::word_t data_in,
	input  deq_pkg::word_t left_data,
	input  logic           left_valid,
	input  deq_pkg::word_t right_data,
	input  logic           right_valid,
	output deq_pkg::word_t data,
	output logic           valid,
	output deq_pkg::word_t tail_data
);
	import deq_pkg::*;

	word_t data_q;
	logic  valid_q;
	logic  is_tail;
	logic  is_gap;

	// tail: last occupied cell; gap: first free cell
	assign is_tail = valid_q && !right_valid;
	assign is_gap  = !valid_q && left_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.push_front) begin
			valid_q <= left_valid;
		end else if (ctrl.push_back && is_gap) begin
			valid_q <= 1'b1;
		end else if (ctrl.pop_front) begin
			valid_q <= right_valid;
		end else if (ctrl.pop_back && is_tail) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push_front) begin
			data_q <= left_data;
		end else if (ctrl.push_back && is_gap) begin
			data_q <= data_in;
		end else if (ctrl.pop_front) begin
			data_q <= right_data;
		end
	end

	assign data      = data_q;
	assign valid     = valid_q;
	assign tail_data = is_tail ? data_q : '0;

endmodule

FILE: rtl/double_ended_queue.sv
// Channel  Dir  Beat
// req      in   opcode, data_in
// rsp      out  data_out, status, is_empty, is_full, occupancy
//
// One beat on req gives one beat on rsp in the next cycle; one item per cycle while rsp is not stalled.
// Entries live in a row of cells that shift as a whole on front operations.
// Reset empties the queue; no clearing pass, data words are never reset.
// req.ready is low only while a rsp beat is held and rsp.ready is low.
module double_ended_queue #(
	parameter int DEPTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	deq_in_if.sink     req,
	deq_out_if.source  rsp
);
	import deq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_nxt;
	logic             empty;
	logic             full;
	logic             take;
	ctrl_t            ctrl;
	status_t          st;
	word_t            popped;
	word_t            tail_or;
	word_t            cell_data [DEPTH];
	word_t            cell_tail [DEPTH];
	logic [DEPTH-1:0] cell_valid;

	logic    rsp_valid_q;
	word_t   data_out_q;
	status_t status_q;
	logic    is_empty_q;
	logic    is_full_q;
	occ_t    occupancy_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign take      = req.valid && req.ready;
	assign empty     = (count_q == '0);
	assign full      = (count_q == CW'(DEPTH));

	always_comb begin
		tail_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tail_or = tail_or | cell_tail[i];
		end
	end

	always_comb begin
		ctrl      = '0;
		st        = ST_OK;
		popped    = '0;
		count_nxt = count_q;
		case (req.opcode)
			OP_PUSH_FRONT: begin
				if (full) begin
					st = ST_OVERFLOW;
				end else begin
					ctrl.push_front = take;
					count_nxt       = count_q + CW'(1);
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					st = ST_OVERFLOW;
				end else begin
					ctrl.push_back = take;
					count_nxt      = count_q + CW'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					st = ST_UNDERFLOW;
				end else begin
					ctrl.pop_front = take;
					popped         = cell_data[0];
					count_nxt      = count_q - CW'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					st = ST_UNDERFLOW;
				end else begin
					ctrl.pop_back = take;
					popped        = tail_or;
					count_nxt     = count_q - CW'(1);
				end
			end
			default: begin
				st = ST_OK;
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t l_data;
		logic  l_valid;
		word_t r_data;
		logic  r_valid;

		if (i == 0) begin : g_first
			assign l_data  = req.data_in;
			assign l_valid = 1'b1;
		end else begin : g_mid_l
			assign l_data  = cell_data[i-1];
			assign l_valid = cell_valid[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign r_data  = '0;
			assign r_valid = 1'b0;
		end else begin : g_mid_r
			assign r_data  = cell_data[i+1];
			assign r_valid = cell_valid[i+1];
		end

		deq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.data_in     (req.data_in),
			.left_data   (l_data),
			.left_valid  (l_valid),
			.right_data  (r_data),
			.right_valid (r_valid),
			.data        (cell_data[i]),
			.valid       (cell_valid[i]),
			.tail_data   (cell_tail[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q <= count_nxt;
			end
			if (take) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_out_q  <= popped;
			status_q    <= st;
			is_empty_q  <= (count_nxt == '0);
			is_full_q   <= (count_nxt == CW'(DEPTH));
			occupancy_q <= OCC_W'(count_nxt);
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.data_out  = data_out_q;
	assign rsp.status    = status_q;
	assign rsp.is_empty  = is_empty_q;
	assign rsp.is_full   = is_full_q;
	assign rsp.occupancy = occupancy_q;

endmodule
